@@ sv/swsfr_pkg.sv @@
// Package for the single-wire sensor frame receiver.
// Holds beat payload types, status codes and frame constants; no dependencies.
package swsfr_pkg;

  // Frame geometry
  localparam int unsigned FrameLen      = 40;
  localparam int unsigned CountWidth    = 6;
  localparam int unsigned ElapsedWidth  = 16;
  localparam int unsigned DefTimeWidth  = 16;

  // Register reset value and register index
  localparam logic [7:0] ThresholdReset = 8'd30;
  localparam logic       RegThreshold   = 1'b0;

  // Input operation codes
  localparam logic OpArm  = 1'b0;
  localparam logic OpEdge = 1'b1;

  // Result status codes
  localparam logic [1:0] StBusy    = 2'd0;
  localparam logic [1:0] StValid   = 2'd1;
  localparam logic [1:0] StChkFail = 2'd2;
  localparam logic [1:0] StBadSync = 2'd3;

  typedef struct packed {
    logic                    operation;
    logic                    level;
    logic [ElapsedWidth-1:0] elapsed_us;
  } in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [7:0]            humidity_whole;
    logic [7:0]            humidity_fraction;
    logic [7:0]            temperature_whole;
    logic [7:0]            temperature_fraction;
    logic [7:0]            check_byte;
    logic [CountWidth-1:0] bits_received;
  } out_t;

endpackage

@@ sv/swsfr_core.sv @@
// Receiver state machine and bit decoder for the single-wire sensor frame.
// Depends on swsfr_pkg; updates state and forms the result of one beat when fired.
module swsfr_core import swsfr_pkg::*; #(
  parameter int unsigned TIME_WIDTH = DefTimeWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  in_t        item_i,
  input  logic [7:0] threshold_i,
  output out_t       result_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhWaitLow,
    PhWaitHigh,
    PhReceive
  } phase_e;

  // Only the low TIME_WIDTH bits (at most ElapsedWidth) of the elapsed time count
  localparam int unsigned UsedWidth = (TIME_WIDTH < ElapsedWidth) ? TIME_WIDTH : ElapsedWidth;
  localparam logic [ElapsedWidth-1:0] TimeMask =
    ElapsedWidth'((33'd1 << UsedWidth) - 33'd1);
  localparam logic [CountWidth-1:0] LastBit  = CountWidth'(FrameLen - 1);
  localparam logic [CountWidth-1:0] FullCnt  = CountWidth'(FrameLen);

  phase_e                phase_q, phase_d;
  logic                  first_fall_q, first_fall_d;
  logic [CountWidth-1:0] bit_count_q, bit_count_d;
  logic [FrameLen-1:0]   frame_q, frame_d;
  logic [1:0]            status;

  logic [ElapsedWidth-1:0] elapsed;
  logic                    bit_one;
  logic [CountWidth-1:0]   bit_idx;
  logic [7:0]              sum;

  assign elapsed = item_i.elapsed_us & TimeMask;
  assign bit_one = elapsed >= {{(ElapsedWidth-8){1'b0}}, threshold_i};
  assign bit_idx = LastBit - bit_count_q;
  // The last bit lands in the check byte, so the four data bytes are already final
  assign sum     = frame_q[39:32] + frame_q[31:24] + frame_q[23:16] + frame_q[15:8];

  // Decode one beat
  always_comb begin
    phase_d      = phase_q;
    first_fall_d = first_fall_q;
    bit_count_d  = bit_count_q;
    frame_d      = frame_q;
    status       = StBusy;
    if (item_i.operation == OpArm) begin
      phase_d      = PhWaitLow;
      first_fall_d = 1'b0;
      bit_count_d  = '0;
      frame_d      = '0;
    end else begin
      case (phase_q)
        PhWaitLow: begin
          if (item_i.level) begin
            status  = StBadSync;
            phase_d = PhIdle;
          end else begin
            phase_d = PhWaitHigh;
          end
        end
        PhWaitHigh: begin
          if (!item_i.level) begin
            status  = StBadSync;
            phase_d = PhIdle;
          end else begin
            phase_d = PhReceive;
          end
        end
        PhReceive: begin
          if (!item_i.level) begin
            if (!first_fall_q) begin
              first_fall_d = 1'b1;
            end else if (bit_count_q < FullCnt) begin
              if (bit_one) begin
                frame_d[bit_idx] = 1'b1;
              end
              bit_count_d = bit_count_q + CountWidth'(1);
              // Check the frame on its last bit
              if (bit_count_d >= FullCnt) begin
                status  = (frame_d[7:0] != 8'd0 && frame_d[7:0] == sum) ? StValid : StChkFail;
                phase_d = PhIdle;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields show the state after the beat
  always_comb begin
    result_o.status               = status;
    result_o.humidity_whole       = frame_d[39:32];
    result_o.humidity_fraction    = frame_d[31:24];
    result_o.temperature_whole    = frame_d[23:16];
    result_o.temperature_fraction = frame_d[15:8];
    result_o.check_byte           = frame_d[7:0];
    result_o.bits_received        = bit_count_d;
  end

  // Hold receiver state; advance on each fired beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      first_fall_q <= 1'b0;
      bit_count_q  <= '0;
      frame_q      <= '0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      first_fall_q <= first_fall_d;
      bit_count_q  <= bit_count_d;
      frame_q      <= frame_d;
    end
  end

endmodule

@@ sv/single_wire_sensor_frame_receiver.sv @@
// Single-wire sensor frame receiver: each input beat yields one result beat.
// Throughput one beat per cycle unless the output stalls: input register, one decode step, result register.
// Reset clears the receiver to idle with an empty frame and threshold 30 us;
// no clearing pass is needed, beats are taken from the first cycle after reset.
// Depends on swsfr_pkg and swsfr_core.
module single_wire_sensor_frame_receiver import swsfr_pkg::*; #(
  parameter int unsigned TIME_WIDTH = DefTimeWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] threshold_q;
  logic       in_full_q;
  in_t        in_q;
  logic       out_valid_q;
  out_t       out_q;
  out_t       result;
  logic       out_free, advance, in_take;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegThreshold) ? {24'd0, threshold_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegThreshold) begin
      threshold_q <= pwdata[7:0];
    end
  end

  // Beat flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_full_q && out_free;
  assign in_stall_o = in_full_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_full_q <= 1'b1;
      end else if (advance) begin
        in_full_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture input and result payloads
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  swsfr_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .item_i     (in_q),
    .threshold_i(threshold_q),
    .result_o   (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Count never runs past a full frame
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bits_received <= 6'(FrameLen))
    else $error("bits_received beyond frame length");

  // A checked frame always carries every bit
  a_check_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StValid || out_data_o.status == StChkFail)
    |-> out_data_o.bits_received == 6'(FrameLen))
    else $error("checksum status on a partial frame");

  // Bad sync happens only before any bit is decoded
  a_sync_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StBadSync |-> out_data_o.bits_received == '0)
    else $error("bad sync with decoded bits");

  // An accepted beat lands in the input register
  a_take_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_full_q)
    else $error("accepted beat lost");

endmodule
